// ----- rtl/rng_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the relative neighborhood graph core.
// Used by the control sequencer, the distance pipeline and the top level.
package rng_pkg;

  localparam int DEF_MAX_POINTS = 32;
  localparam int DEF_COORD_BITS = 16;
  localparam int LIMIT_POINTS   = 32;  // rows and masks cover at most this many points
  localparam int FIELD_BITS     = 16;  // width of one coordinate field on the input bus
  localparam int ROW_BITS       = 5;
  localparam int MASK_BITS      = 32;
  localparam int IN_DATA_BITS   = 32;
  localparam int OUT_DATA_BITS  = 40;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_ROW,
    ST_CAPI,
    ST_DIJ,
    ST_WIT,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef enum logic {
    KIND_DIJ,
    KIND_WIT
  } kind_t;

  // Tag that travels with the head point into the distance pipeline.
  typedef struct packed {
    logic  valid;
    kind_t kind;
    logic  hit;    // head point is point j of the current pair
    logic  m_ok;   // head point is a stored point of this set
    logic  last;   // final witness of the current pair
    logic  cap_i;  // latch head point as point i of the row
  } feed_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic witness;
  } res_t;

endpackage

// ----- rtl/rng_cell.sv -----
`timescale 1ns / 1ps
// One point cell of the rotating store: holds one point, loads it from the
// input bus or takes its neighbor's point while the ring rotates.
module rng_cell #(
  parameter int W = 16
) (
  input  logic                clk,
  input  logic                we,
  input  logic                shift,
  input  logic signed [W-1:0] load_x,
  input  logic signed [W-1:0] load_y,
  input  logic signed [W-1:0] nbr_x,
  input  logic signed [W-1:0] nbr_y,
  output logic signed [W-1:0] x,
  output logic signed [W-1:0] y
);

  logic signed [W-1:0] x_r;
  logic signed [W-1:0] y_r;

  always_ff @(posedge clk) begin
    if (we) begin
      x_r <= load_x;
      y_r <= load_y;
    end else if (shift) begin
      x_r <= nbr_x;
      y_r <= nbr_y;
    end
  end

  assign x = x_r;
  assign y = y_r;

endmodule

// ----- rtl/rng_dist.sv -----
`timescale 1ns / 1ps
// Four-stage squared distance pipeline: head point against points i and j,
// capture of d(i,j) and the strict witness test. Depends on rng_pkg.
module rng_dist import rng_pkg::*; #(
  parameter int EXT = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  feed_t                 feed,
  input  logic signed [EXT-1:0] head_x,
  input  logic signed [EXT-1:0] head_y,
  output res_t                  res
);

  localparam int AW = EXT + 1;      // magnitude of a coordinate difference
  localparam int DW = 2 * EXT + 2;  // squares and their sums

  logic signed [EXT-1:0] pix_r, piy_r, pjx_r, pjy_r;
  logic [AW-1:0] axi_r, ayi_r, axj_r, ayj_r;
  logic [DW-1:0] sxi_r, syi_r, sxj_r, syj_r;
  logic [DW-1:0] di_r, dj_r, dij_r;
  feed_t t1_r, t2_r, t3_r;
  res_t  res_r;
  logic  cap_j;

  function automatic logic [AW-1:0] abs_diff(input logic signed [EXT-1:0] a,
                                             input logic signed [EXT-1:0] b);
    logic signed [AW-1:0] d;
    d = AW'(a) - AW'(b);
    return d[AW-1] ? AW'(-d) : AW'(d);
  endfunction

  assign cap_j = feed.valid && (feed.kind == KIND_DIJ) && feed.hit;

  always_ff @(posedge clk) begin
    if (feed.cap_i) begin
      pix_r <= head_x;
      piy_r <= head_y;
    end
    if (cap_j) begin
      pjx_r <= head_x;
      pjy_r <= head_y;
    end
    axi_r <= abs_diff(head_x, pix_r);
    ayi_r <= abs_diff(head_y, piy_r);
    axj_r <= abs_diff(head_x, pjx_r);
    ayj_r <= abs_diff(head_y, pjy_r);
    sxi_r <= DW'(axi_r) * DW'(axi_r);
    syi_r <= DW'(ayi_r) * DW'(ayi_r);
    sxj_r <= DW'(axj_r) * DW'(axj_r);
    syj_r <= DW'(ayj_r) * DW'(ayj_r);
    di_r  <= sxi_r + syi_r;
    dj_r  <= sxj_r + syj_r;
    if (t3_r.valid && (t3_r.kind == KIND_DIJ) && t3_r.hit) begin
      dij_r <= di_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r  <= '0;
      t2_r  <= '0;
      t3_r  <= '0;
      res_r <= '0;
    end else begin
      t1_r          <= feed;
      t2_r          <= t1_r;
      t3_r          <= t2_r;
      res_r.valid   <= t3_r.valid;
      res_r.last    <= t3_r.valid && t3_r.last;
      res_r.witness <= t3_r.valid && (t3_r.kind == KIND_WIT) && t3_r.m_ok &&
                       (di_r < dij_r) && (dj_r < dij_r);
    end
  end

  assign res = res_r;

endmodule

// ----- rtl/rng_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer: point loading, ring rotation, pair and row scheduling, edge
// mask assembly and the output register. Depends on rng_pkg.
module rng_ctrl import rng_pkg::*; #(
  parameter int CAP = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  input  logic                         in_tlast,
  output logic                         in_tready,
  output logic                         load_we,
  output logic [$clog2(CAP+1)-1:0]     count,
  output logic                         rotate,
  output feed_t                        feed,
  input  res_t                         res,
  output logic                         ov_valid,
  input  logic                         ov_ready,
  output logic [$clog2(CAP)-1:0]       ov_row,
  output logic [CAP-1:0]               ov_mask,
  output logic                         ov_last,
  output logic                         ov_drop
);

  localparam int IB = $clog2(CAP);
  localparam int CB = $clog2(CAP + 1);

  state_t        state_r, state_nxt;
  logic [CB-1:0] count_r, count_nxt, n_r, n_nxt;
  logic          ovf_r, ovf_nxt, drop_r, drop_nxt;
  logic [IB-1:0] i_r, i_nxt, j_r, j_nxt, head_r, head_nxt;
  logic [CAP-1:0] mask_r, mask_nxt;
  logic          wit_r, wit_nxt;
  logic          ov_valid_r, ov_valid_nxt, ov_last_r, ov_last_nxt, ov_drop_r, ov_drop_nxt;
  logic [IB-1:0] ov_row_r, ov_row_nxt;
  logic [CAP-1:0] ov_mask_r, ov_mask_nxt;
  logic          fire, head_end;
  logic [CB-1:0] i_plus, j_plus;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      count_r    <= '0;
      ovf_r      <= 1'b0;
      head_r     <= '0;
      ov_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      ovf_r      <= ovf_nxt;
      head_r     <= head_nxt;
      ov_valid_r <= ov_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    drop_r    <= drop_nxt;
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    mask_r    <= mask_nxt;
    wit_r     <= wit_nxt;
    ov_row_r  <= ov_row_nxt;
    ov_mask_r <= ov_mask_nxt;
    ov_last_r <= ov_last_nxt;
    ov_drop_r <= ov_drop_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    ovf_nxt      = ovf_r;
    n_nxt        = n_r;
    drop_nxt     = drop_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    mask_nxt     = mask_r;
    wit_nxt      = wit_r;
    ov_valid_nxt = ov_valid_r;
    ov_row_nxt   = ov_row_r;
    ov_mask_nxt  = ov_mask_r;
    ov_last_nxt  = ov_last_r;
    ov_drop_nxt  = ov_drop_r;
    feed         = '0;
    feed.kind    = KIND_DIJ;

    in_tready = (state_r == ST_LOAD);
    fire      = in_tvalid && in_tready;
    load_we   = fire && (count_r < CB'(CAP));
    rotate    = (state_r == ST_CAPI) || (state_r == ST_DIJ) || (state_r == ST_WIT);
    head_end  = (head_r == IB'(CAP - 1));
    i_plus    = CB'(i_r) + CB'(1);
    j_plus    = CB'(j_r) + CB'(1);
    head_nxt  = rotate ? (head_end ? '0 : head_r + IB'(1)) : head_r;

    if (ov_valid_r && ov_ready) begin
      ov_valid_nxt = 1'b0;
    end
    if (res.valid && res.witness) begin
      wit_nxt = 1'b1;
    end

    unique case (state_r)
      ST_LOAD: begin
        if (fire) begin
          if (load_we) begin
            count_nxt = count_r + CB'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            n_nxt     = load_we ? count_r + CB'(1) : count_r;
            drop_nxt  = ovf_r || !load_we;
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            i_nxt     = '0;
            state_nxt = ST_ROW;
          end
        end
      end
      ST_ROW: begin
        mask_nxt = '0;
        j_nxt    = IB'(i_plus);
        state_nxt = (i_plus < n_r) ? ST_CAPI : ST_EMIT;
      end
      ST_CAPI: begin
        feed.cap_i = (head_r == i_r);
        if (head_end) begin
          state_nxt = ST_DIJ;
        end
      end
      ST_DIJ: begin
        feed.valid = 1'b1;
        feed.kind  = KIND_DIJ;
        feed.hit   = (head_r == j_r);
        if (head_end) begin
          wit_nxt   = 1'b0;
          state_nxt = ST_WIT;
        end
      end
      ST_WIT: begin
        feed.valid = 1'b1;
        feed.kind  = KIND_WIT;
        feed.m_ok  = (CB'(head_r) < n_r);
        feed.last  = head_end;
        if (head_end) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (res.valid && res.last) begin
          mask_nxt[j_r] = !(wit_r || res.witness);
          if (j_plus < n_r) begin
            j_nxt     = j_r + IB'(1);
            state_nxt = ST_DIJ;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (!ov_valid_r || ov_ready) begin
          ov_valid_nxt = 1'b1;
          ov_row_nxt   = i_r;
          ov_mask_nxt  = mask_r;
          ov_last_nxt  = (i_plus == n_r);
          ov_drop_nxt  = drop_r;
          if (i_plus == n_r) begin
            state_nxt = ST_LOAD;
          end else begin
            i_nxt     = i_r + IB'(1);
            state_nxt = ST_ROW;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  assign count    = count_r;
  assign ov_valid = ov_valid_r;
  assign ov_row   = ov_row_r;
  assign ov_mask  = ov_mask_r;
  assign ov_last  = ov_last_r;
  assign ov_drop  = ov_drop_r;

endmodule

// ----- rtl/relative_neighborhood_graph_core.sv -----
`timescale 1ns / 1ps
// A set of n points is computed after its last point, using C = min(MAX_POINTS, 32) ring
// cells; each pair runs a full ring revolution for d(i,j) and another for the witnesses,
// then drains the distance pipeline. Loading takes one cycle per point, and no point is
// taken while a set is being computed.
// Reset (rst_n low, synchronous) empties the point set, clears the overflow flag and the
// output valid flag; the point cells themselves are not cleared.
module relative_neighborhood_graph_core import rng_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_DATA_BITS-1:0]  in_tdata,   // x_coord[15:0], y_coord[31:16]
  input  logic                     in_tlast,   // last_point
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0] out_tdata,  // row_index[4:0], neighbor_mask[36:5], zeros
  output logic                     out_tlast,  // last_row
  output logic                     out_tuser   // points_dropped
);

  // Store capacity is bounded by the width of row_index and neighbor_mask.
  localparam int CAP = (MAX_POINTS < LIMIT_POINTS) ? MAX_POINTS : LIMIT_POINTS;
  // Coordinates narrower than the bus field wrap to their low bits, sign-extended.
  localparam int EXT = (COORD_BITS < FIELD_BITS) ? COORD_BITS : FIELD_BITS;
  localparam int IB  = $clog2(CAP);
  localparam int CB  = $clog2(CAP + 1);

  logic signed [EXT-1:0] cell_x [CAP];
  logic signed [EXT-1:0] cell_y [CAP];
  logic signed [EXT-1:0] load_x, load_y;
  logic                  load_we, rotate;
  logic [CB-1:0]         count;
  feed_t                 feed;
  res_t                  res;
  logic [IB-1:0]         ov_row;
  logic [CAP-1:0]        ov_mask;

  assign load_x = in_tdata[EXT-1:0];
  assign load_y = in_tdata[FIELD_BITS +: EXT];

  // The ring: cell k holds point k at rest, and each rotation step moves every
  // point one cell toward cell 0, which feeds the distance pipeline. Rotation only
  // ever runs in whole revolutions, so the ring is back at rest whenever points load.
  for (genvar k = 0; k < CAP; k++) begin : g_cell
    rng_cell #(.W(EXT)) u_cell (
      .clk    (clk),
      .we     (load_we && (count == CB'(k))),
      .shift  (rotate),
      .load_x (load_x),
      .load_y (load_y),
      .nbr_x  (cell_x[(k + 1) % CAP]),
      .nbr_y  (cell_y[(k + 1) % CAP]),
      .x      (cell_x[k]),
      .y      (cell_y[k])
    );
  end

  // The sequencer owns the point count, the pair loops and the output register.
  rng_ctrl #(.CAP(CAP)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .load_we   (load_we),
    .count     (count),
    .rotate    (rotate),
    .feed      (feed),
    .res       (res),
    .ov_valid  (out_tvalid),
    .ov_ready  (out_tready),
    .ov_row    (ov_row),
    .ov_mask   (ov_mask),
    .ov_last   (out_tlast),
    .ov_drop   (out_tuser)
  );

  // Squared distances from the head cell to points i and j, compared exactly
  // against d(i,j) so no square root is ever needed.
  rng_dist #(.EXT(EXT)) u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .feed   (feed),
    .head_x (cell_x[0]),
    .head_y (cell_y[0]),
    .res    (res)
  );

  assign out_tdata = {{(OUT_DATA_BITS - MASK_BITS - ROW_BITS){1'b0}},
                      MASK_BITS'(ov_mask), ROW_BITS'(ov_row)};

endmodule

// ----- rtl/rng_check.sv -----
`timescale 1ns / 1ps
// Port-level checker for the relative neighborhood graph core, bound to the
// top level. Depends on rng_pkg for bus widths.
module rng_check import rng_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_tvalid,
  input logic                     in_tready,
  input logic                     in_tlast,
  input logic                     out_tvalid,
  input logic                     out_tready,
  input logic [OUT_DATA_BITS-1:0] out_tdata,
  input logic                     out_tlast,
  input logic                     out_tuser
);

  // A held result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))
    else $error("result payload changed while stalled");

  // Closing a set stops loading until the graph is computed.
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input accepted right after the last point");

  // While rows of a set remain, no new point may be taken.
  a_rows_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |-> !in_tready)
    else $error("input open while rows are still pending");

  // Only higher-indexed neighbors are reported, so point 0 is never a neighbor.
  a_mask_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[ROW_BITS])
    else $error("neighbor mask reports point 0");

endmodule

bind relative_neighborhood_graph_core rng_check u_rng_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

// ----- verif/relative_neighborhood_graph_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for relative_neighborhood_graph_core: streams point sets,
// predicts the graph rows in a scoreboard class and checks every row. Needs rng_pkg.
module relative_neighborhood_graph_core_tb;
  import rng_pkg::*;

  // The store keeps at most 32 points, and coordinates keep at most 16 bits.
  localparam int CAPACITY  = (DEF_MAX_POINTS < LIMIT_POINTS) ? DEF_MAX_POINTS : LIMIT_POINTS;
  localparam int KEEP_BITS = (DEF_COORD_BITS < FIELD_BITS) ? DEF_COORD_BITS : FIELD_BITS;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 110;

  typedef struct packed {
    logic [ROW_BITS-1:0]  row;
    logic [MASK_BITS-1:0] mask;
    logic                 last_row;
    logic                 dropped;
  } graph_row_t;

  // Scoreboard: keeps its own copy of the point store, computes the graph rows when a
  // set closes, and compares each row that leaves the block with the oldest prediction.
  class rng_scoreboard;
    longint     px[LIMIT_POINTS];
    longint     py[LIMIT_POINTS];
    int         count;
    bit         overflow;
    graph_row_t expected_rows[$];
    int         errors;
    int         rows_checked;
    int         sets_closed;
    int         overflow_sets;
    int         largest_set;

    function new();
      count         = 0;
      overflow      = 1'b0;
      errors        = 0;
      rows_checked  = 0;
      sets_closed   = 0;
      overflow_sets = 0;
      largest_set   = 0;
    endfunction

    // Only the low KEEP_BITS of a coordinate count, sign-extended.
    function longint widen(logic [FIELD_BITS-1:0] raw);
      longint v;
      v = longint'(raw) & ((longint'(1) << KEEP_BITS) - 1);
      if (v[KEEP_BITS-1])
        v = v - (longint'(1) << KEEP_BITS);
      return v;
    endfunction

    function longint dist2(int a, int b);
      longint dx;
      longint dy;
      dx = px[a] - px[b];
      dy = py[a] - py[b];
      return dx * dx + dy * dy;
    endfunction

    // Called for every accepted input transaction.
    function void note_point(logic [FIELD_BITS-1:0] x, logic [FIELD_BITS-1:0] y,
                             logic closes);
      longint               dij;
      logic [MASK_BITS-1:0] mask;
      bit                   linked;
      graph_row_t           r;
      if (count < CAPACITY) begin
        px[count] = widen(x);
        py[count] = widen(y);
        count++;
      end else begin
        overflow = 1'b1;
      end
      if (!closes)
        return;
      sets_closed++;
      if (overflow)
        overflow_sets++;
      if (count > largest_set)
        largest_set = count;
      for (int i = 0; i < count; i++) begin
        mask = '0;
        for (int j = i + 1; j < count; j++) begin
          // A pair is linked unless some third point is strictly nearer to both ends.
          dij    = dist2(i, j);
          linked = 1'b1;
          for (int m = 0; m < count; m++) begin
            if (m != i && m != j && dist2(m, i) < dij && dist2(m, j) < dij)
              linked = 1'b0;
          end
          if (linked)
            mask[j] = 1'b1;
        end
        r.row      = i[ROW_BITS-1:0];
        r.mask     = mask;
        r.last_row = (i + 1 == count);
        r.dropped  = overflow;
        expected_rows.push_back(r);
      end
      count    = 0;
      overflow = 1'b0;
    endfunction

    function void complain(string msg);
      errors++;
      if (errors <= 10)
        $display("MISMATCH: %s", msg);
    endfunction

    // Called for every accepted output transaction.
    function void check_row(graph_row_t got);
      graph_row_t want;
      if (expected_rows.size() == 0) begin
        complain($sformatf("unexpected row %0d mask %h last %b dropped %b",
                           got.row, got.mask, got.last_row, got.dropped));
        return;
      end
      want = expected_rows.pop_front();
      rows_checked++;
      if (got.row !== want.row)
        complain($sformatf("row_index expected %0d actual %0d", want.row, got.row));
      if (got.mask !== want.mask)
        complain($sformatf("row %0d neighbor_mask expected %h actual %h",
                           want.row, want.mask, got.mask));
      if (got.last_row !== want.last_row)
        complain($sformatf("row %0d last_row expected %b actual %b",
                           want.row, want.last_row, got.last_row));
      if (got.dropped !== want.dropped)
        complain($sformatf("row %0d points_dropped expected %b actual %b",
                           want.row, want.dropped, got.dropped));
    endfunction

    function int pending();
      return expected_rows.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata = '0;   // x_coord[15:0], y_coord[31:16]
  logic                     in_tlast = 1'b0; // last_point
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;       // row_index[4:0], neighbor_mask[36:5], zeros
  logic                     out_tlast;       // last_row
  logic                     out_tuser;       // points_dropped

  rng_scoreboard sb = new();
  int send_idle_pct  = 6;
  int recv_stall_pct = 81;
  int cycle_count    = 0;
  int points_sent    = 0;

  relative_neighborhood_graph_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // The receiver stalls at random; the stall rate follows the current idling phase.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Every output transaction is checked against the oldest predicted row. Values read
  // here are the ones present at the edge, since all drivers update with nonblocking
  // assignments.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_row('{out_tdata[ROW_BITS-1:0], out_tdata[ROW_BITS+MASK_BITS-1:ROW_BITS],
                     out_tlast, out_tuser});
  end

  // Guard against a hung block: the slowest legal run is far below this bound.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d rows still expected.",
               cycle_count, sb.pending());
      $display("simulation failed");
      $finish;
    end
  end

  // Idling phases: sender light and receiver heavy, then swapped, then none at all.
  task automatic set_phase(input int phase);
    unique case (phase)
      0: begin
        send_idle_pct  = 6;
        recv_stall_pct = 81;
      end
      1: begin
        send_idle_pct  = 81;
        recv_stall_pct = 6;
      end
      default: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  // Offers one point and waits for its transaction. tvalid stays high into the next
  // point unless the sender decides to idle first.
  task automatic send_point(input logic [FIELD_BITS-1:0] x, input logic [FIELD_BITS-1:0] y,
                            input logic closes);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {y, x};
    in_tlast  <= closes;
    do @(posedge clk); while (!in_tready);
    sb.note_point(x, y, closes);
    points_sent++;
  endtask

  function automatic logic [FIELD_BITS-1:0] extreme_coord();
    unique case ($urandom_range(3))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      default: return 16'hffff;
    endcase
  endfunction

  // One well-formed set of n points. Style 0 spreads points over the whole plane,
  // style 1 packs them into a tiny cluster (coincident points and ties are common),
  // style 2 draws them from the corner values of the coordinate range.
  task automatic send_set(input int n, input int style);
    int                    cx;
    int                    cy;
    logic [FIELD_BITS-1:0] x;
    logic [FIELD_BITS-1:0] y;
    cx = $urandom_range(65000) - 32500;
    cy = $urandom_range(65000) - 32500;
    for (int k = 0; k < n; k++) begin
      unique case (style)
        0: begin
          x = FIELD_BITS'($urandom_range(16'hffff));
          y = FIELD_BITS'($urandom_range(16'hffff));
        end
        1: begin
          x = FIELD_BITS'(cx + int'($urandom_range(6)) - 3);
          y = FIELD_BITS'(cy + int'($urandom_range(6)) - 3);
        end
        default: begin
          x = extreme_coord();
          y = extreme_coord();
        end
      endcase
      send_point(x, y, k == n - 1);
    end
  endtask

  initial begin
    int random_items;
    int set_no;
    int n;
    random_items = 0;
    set_no       = 0;
    set_phase(0);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single point: one row, empty mask, marked as the last row.
    send_point(16'h8000, 16'h7fff, 1'b1);
    // Two coincident points are always linked.
    send_point(16'd5, 16'd5, 1'b0);
    send_point(16'd5, 16'd5, 1'b1);
    // Opposite corners of the plane with the origin between them as a witness.
    send_point(16'h8000, 16'h8000, 1'b0);
    send_point(16'h7fff, 16'h7fff, 1'b0);
    send_point(16'h0000, 16'h0000, 1'b1);
    // Three coincident points and a neighbor.
    send_point(16'd1, 16'd1, 1'b0);
    send_point(16'd1, 16'd1, 1'b0);
    send_point(16'd1, 16'd1, 1'b0);
    send_point(16'd2, 16'd2, 1'b1);
    // Square: sides are edges, diagonals are blocked by a corner.
    send_point(16'd0, 16'd0, 1'b0);
    send_point(16'd10, 16'd0, 1'b0);
    send_point(16'd0, 16'd10, 1'b0);
    send_point(16'd10, 16'd10, 1'b1);
    // Collinear points: the middle one blocks the outer pair.
    send_point(16'hfffc, 16'd0, 1'b0);
    send_point(16'd0, 16'd0, 1'b0);
    send_point(16'd4, 16'd0, 1'b1);
    // A witness at exactly the pair distance does not block the pair.
    send_point(16'd0, 16'd0, 1'b0);
    send_point(16'd2, 16'd0, 1'b0);
    send_point(16'd0, 16'd2, 1'b1);

    // Random sets. The first one overflows the store, its last point included, and a
    // later one fills it exactly; the rest are small so the cubic scan stays short.
    while (random_items < RANDOM_ITEMS) begin
      if (random_items >= (2 * RANDOM_ITEMS) / 3)
        set_phase(2);
      else if (random_items >= RANDOM_ITEMS / 3)
        set_phase(1);
      if (set_no == 0)
        n = CAPACITY + 2;
      else if (set_no == 6)
        n = CAPACITY;
      else
        n = $urandom_range(1, 8);
      send_set(n, $urandom_range(2));
      random_items += n;
      set_no++;
    end
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;

    while (sb.pending() != 0)
      @(posedge clk);
    // Let any stray rows show up before the verdict.
    repeat (100) @(posedge clk);

    $display("Streamed %0d points in %0d sets (largest kept %0d, %0d over capacity).",
             points_sent, sb.sets_closed, sb.largest_set, sb.overflow_sets);
    $display("Checked %0d graph rows across three idling phases, %0d mismatches.",
             sb.rows_checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/rng_pkg.sv
rtl/rng_cell.sv
rtl/rng_dist.sv
rtl/rng_ctrl.sv
rtl/relative_neighborhood_graph_core.sv
rtl/rng_check.sv
verif/relative_neighborhood_graph_core_tb.sv
